/* sv/rpa_pkg.sv */
// Package holding the constants and helper function of the packet airtime calculator.
package rpa_pkg;

	localparam int unsigned InW  = 40;
	localparam int unsigned OutW = 32;

	localparam logic [1:0] BW_500K  = 2'd2;
	localparam logic [3:0] SF_MIN   = 4'd6;
	localparam logic [3:0] SF_MAX   = 4'd12;
	localparam logic [3:0] SF_LDR   = 4'd11;
	localparam logic [2:0] CR_MIN   = 3'd1;
	localparam logic [2:0] CR_MAX   = 3'd4;

	localparam int unsigned RecipShift   = 16;
	localparam int unsigned Div125ShiftA = 26;
	localparam int unsigned Div125ShiftB = 24;
	localparam logic [19:0] RECIP125_A   = 20'd536871;
	localparam logic [17:0] RECIP125_B   = 18'd134218;
	localparam logic [6:0]  CEIL_ADD_125 = 7'd124;
	localparam logic [18:0] PREAMBLE_FRAC = 19'd17;

	typedef struct packed {
		logic       crc_present;
		logic [7:0] payload_bytes;
		logic       implicit_header;
		logic [15:0] preamble_symbols;
		logic [2:0] coding_rate;
		logic [3:0] spreading_factor;
		logic [1:0] bandwidth_code;
	} rpa_in_t;

	// Rounded-up reciprocal of the symbol divisor, scaled by two to the sixteenth.
	function automatic logic [13:0] recip_of(input logic [3:0] d);
		logic [13:0] r;
		case (d)
			4'd6:    r = 14'd10923;
			4'd7:    r = 14'd9363;
			4'd8:    r = 14'd8192;
			4'd9:    r = 14'd7282;
			4'd10:   r = 14'd6554;
			4'd11:   r = 14'd5958;
			4'd12:   r = 14'd5462;
			default: r = 14'd8192;
		endcase
		return r;
	endfunction

endpackage

/* sv/radio_packet_airtime.sv */
// Pipelined calculator of packet airtime and payload symbol count.
//
// Channel | Direction | Handshake              | Content
// s_axis  | in        | tvalid/tready, 40 bits | one packet description per item
// m_axis  | out       | tvalid/tready, 32 bits | airtime in ms and payload symbols
//
// Eight register stages; one item per cycle while the output is not stalled.
// The depth follows the three reciprocal multiplications and their registers.
// Each stage loads when it is empty or its successor moves, so bubbles close up.
// A stall holds each stage with no bubble after it; nothing is lost or repeated.
// Reset clears the valid bits only.
module radio_packet_airtime
	import rpa_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// bandwidth_code, spreading_factor, coding_rate, preamble_symbols,
	// implicit_header, payload_bytes, crc_present, five zero bits
	input  logic [InW-1:0]  s_axis_tdata,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// airtime_ms, payload_symbols
	output logic [OutW-1:0] m_axis_tdata
);

	rpa_in_t in_w;
	assign in_w = rpa_in_t'(s_axis_tdata[34:0]);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8;

	assign ld8 = !vld_s8 || m_axis_tready;
	assign ld7 = !vld_s7 || ld8;
	assign ld6 = !vld_s6 || ld7;
	assign ld5 = !vld_s5 || ld6;
	assign ld4 = !vld_s4 || ld5;
	assign ld3 = !vld_s3 || ld4;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;
	assign s_axis_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= s_axis_tvalid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;
			if (ld8) vld_s8 <= vld_s7;
		end
	end

	// Stage 1: saturate the fields and form the ceiling numerator.
	logic [1:0]  bw_c;
	logic [3:0]  sf_c;
	logic [2:0]  cr_c;
	logic        de_c;
	logic [3:0]  d_c;
	logic signed [11:0] m_c;
	logic [9:0]  x_c;

	always_comb begin
		bw_c = (in_w.bandwidth_code > BW_500K) ? BW_500K : in_w.bandwidth_code;
		sf_c = in_w.spreading_factor;
		if (sf_c < SF_MIN) sf_c = SF_MIN;
		if (sf_c > SF_MAX) sf_c = SF_MAX;
		cr_c = in_w.coding_rate;
		if (cr_c < CR_MIN) cr_c = CR_MIN;
		if (cr_c > CR_MAX) cr_c = CR_MAX;
		de_c = (bw_c == 2'd0) && (sf_c >= SF_LDR);
		d_c  = sf_c - {2'b00, de_c, 1'b0};
		m_c  = $signed({3'b000, in_w.payload_bytes, 1'b0}) - $signed({8'd0, sf_c})
			+ 12'sd7 + $signed({9'd0, in_w.crc_present, 2'b00})
			- $signed(in_w.implicit_header ? 12'd5 : 12'd0);
		x_c  = (m_c > 12'sd0) ? 10'(m_c + $signed({8'd0, d_c}) - 12'sd1) : 10'd0;
	end

	logic [9:0]  x_s1;
	logic [13:0] rcp_s1;
	logic [3:0]  sf_s1, sf_s2, sf_s3;
	logic [1:0]  bw_s1, bw_s2, bw_s3;
	logic [2:0]  cr_s1, cr_s2;
	logic [15:0] pre_s1, pre_s2, pre_s3;
	logic [23:0] prod_s2;
	logic [9:0]  nsym_s3, nsym_s4, nsym_s5, nsym_s6, nsym_s7, nsym_s8;
	logic [18:0] qtr_s4, qtr_s5;
	logic [3:0]  sh_s4, sh_s5, sh_s6, sh_s7;
	logic [38:0] prod_s5;
	logic [12:0] a_s6, a_s7;
	logic [16:0] t_s6;
	logic [34:0] prod_s7;
	logic [21:0] ms_s8;

	logic [12:0] a_c;
	logic [6:0]  r_c;

	assign a_c = prod_s5[38:Div125ShiftA];
	assign r_c = 7'(qtr_s5 - 19'(a_c) * 19'd125);

	always_ff @(posedge clk) begin
		if (ld1) begin
			x_s1   <= x_c;
			rcp_s1 <= recip_of(d_c);
			sf_s1  <= sf_c;
			bw_s1  <= bw_c;
			cr_s1  <= cr_c;
			pre_s1 <= in_w.preamble_symbols;
		end
		if (ld2) begin
			prod_s2 <= 24'(x_s1) * 24'(rcp_s1);
			sf_s2   <= sf_s1;
			bw_s2   <= bw_s1;
			cr_s2   <= cr_s1;
			pre_s2  <= pre_s1;
		end
		if (ld3) begin
			nsym_s3 <= 10'd8 + 10'(prod_s2[23:RecipShift]) * 10'({1'b0, cr_s2} + 4'd4);
			sf_s3   <= sf_s2;
			bw_s3   <= bw_s2;
			pre_s3  <= pre_s2;
		end
		if (ld4) begin
			qtr_s4  <= {1'b0, pre_s3, 2'b00} + PREAMBLE_FRAC + {7'd0, nsym_s3, 2'b00};
			sh_s4   <= sf_s3 - {2'b00, bw_s3} - 4'd2;
			nsym_s4 <= nsym_s3;
		end
		if (ld5) begin
			prod_s5 <= 39'(qtr_s4) * 39'(RECIP125_A);
			qtr_s5  <= qtr_s4;
			sh_s5   <= sh_s4;
			nsym_s5 <= nsym_s4;
		end
		if (ld6) begin
			a_s6    <= a_c;
			t_s6    <= (17'(r_c) << sh_s5) + 17'(CEIL_ADD_125);
			sh_s6   <= sh_s5;
			nsym_s6 <= nsym_s5;
		end
		if (ld7) begin
			prod_s7 <= 35'(t_s6) * 35'(RECIP125_B);
			a_s7    <= a_s6;
			sh_s7   <= sh_s6;
			nsym_s7 <= nsym_s6;
		end
		if (ld8) begin
			ms_s8   <= (22'(a_s7) << sh_s7) + 22'(prod_s7[33:Div125ShiftB]);
			nsym_s8 <= nsym_s7;
		end
	end

	assign m_axis_tvalid = vld_s8;
	assign m_axis_tdata  = {nsym_s8, ms_s8};

`ifndef SYNTHESIS
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (nsym_s8 >= 10'd8) && (nsym_s8 <= 10'd700))
		else $error("payload symbol count out of range");

	a_ms_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (ms_s8 != 22'd0))
		else $error("airtime of zero milliseconds");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && vld_s1))
		else $error("input refused without a full stalled pipeline");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (t_s6 <= 17'd127100))
		else $error("remainder term out of range");
`endif

endmodule

/* test/tb_radio_packet_airtime.sv */
// Self-checking testbench for the pipelined packet airtime and payload symbol calculator.
module tb_radio_packet_airtime
	import rpa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] BW_125K   = 2'd0;
	localparam logic [1:0] BW_250K   = 2'd1;
	localparam logic [1:0] BW_UNUSED = 2'd3;

	typedef struct packed {
		logic [9:0]  payload_symbols;
		logic [21:0] airtime_ms;
	} packet_timing_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	// bandwidth_code, spreading_factor, coding_rate, preamble_symbols,
	// implicit_header, payload_bytes, crc_present, five zero bits
	logic [InW-1:0]  s_axis_tdata = '0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	// airtime_ms, payload_symbols
	logic [OutW-1:0] m_axis_tdata;

	packet_timing_t expected_timing[$];
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             recv_hold_cycles = 0;
	int             packets_sent = 0;
	int             results_checked = 0;
	int             mismatch_count = 0;

	radio_packet_airtime DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic packet_timing_t predict_timing(input rpa_in_t pkt);
		int                bw;
		int                sf;
		int                cr;
		int                ldr;
		int                num;
		int                den;
		int                term;
		longint unsigned   nsym;
		longint unsigned   quarters;
		longint unsigned   divisor;
		longint unsigned   ms;
		packet_timing_t    res;
		bw = int'(pkt.bandwidth_code);
		sf = int'(pkt.spreading_factor);
		cr = int'(pkt.coding_rate);
		if (bw > int'(BW_500K)) bw = int'(BW_500K);
		if (sf < int'(SF_MIN)) sf = int'(SF_MIN);
		if (sf > int'(SF_MAX)) sf = int'(SF_MAX);
		if (cr < int'(CR_MIN)) cr = int'(CR_MIN);
		if (cr > int'(CR_MAX)) cr = int'(CR_MAX);
		ldr = (bw == int'(BW_125K) && sf >= int'(SF_LDR)) ? 1 : 0;
		num = 8 * int'(pkt.payload_bytes) - 4 * sf + 28 + 16 * int'(pkt.crc_present)
			- 20 * int'(pkt.implicit_header);
		den = 4 * (sf - 2 * ldr);
		term = (num > 0) ? (num + den - 1) / den : 0;
		nsym = 64'd8 + longint'(term) * longint'(cr + 4);
		// Airtime counted in quarter symbols so that the 4.25 preamble tail stays exact.
		quarters = 4 * longint'(pkt.preamble_symbols) + 17 + 4 * nsym;
		divisor = 64'd500 << bw;
		ms = ((quarters << sf) + divisor - 1) / divisor;
		res.airtime_ms = ms[21:0];
		res.payload_symbols = nsym[9:0];
		return res;
	endfunction

	always @(negedge clk) begin
		if (recv_hold_cycles > 0) begin
			m_axis_tready = 1'b0;
			recv_hold_cycles = recv_hold_cycles - 1;
		end else begin
			m_axis_tready = (int'($urandom_range(99, 0)) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		packet_timing_t got;
		packet_timing_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_timing.size() == 0) begin
				$error("Result with no packet outstanding: airtime_ms %0d, payload_symbols %0d",
					got.airtime_ms, got.payload_symbols);
				mismatch_count++;
			end else begin
				want = expected_timing.pop_front();
				if (got.airtime_ms !== want.airtime_ms) begin
					$error("airtime_ms: expected %0d, actual %0d", want.airtime_ms, got.airtime_ms);
					mismatch_count++;
				end
				if (got.payload_symbols !== want.payload_symbols) begin
					$error("payload_symbols: expected %0d, actual %0d",
						want.payload_symbols, got.payload_symbols);
					mismatch_count++;
				end
			end
			results_checked++;
		end
		if (s_axis_tvalid && s_axis_tready)
			expected_timing.push_back(predict_timing(rpa_in_t'(s_axis_tdata[$bits(rpa_in_t)-1:0])));
	end

	task automatic send_packet(input rpa_in_t pkt);
		@(negedge clk);
		while (int'($urandom_range(99, 0)) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = {{(InW - $bits(rpa_in_t)){1'b0}}, pkt};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		packets_sent++;
	endtask

	task automatic send_fields(input logic [1:0] bw, input logic [3:0] sf, input logic [2:0] cr,
		input logic [15:0] pre, input logic ih, input logic [7:0] pl, input logic crc);
		rpa_in_t pkt;
		pkt.bandwidth_code = bw;
		pkt.spreading_factor = sf;
		pkt.coding_rate = cr;
		pkt.preamble_symbols = pre;
		pkt.implicit_header = ih;
		pkt.payload_bytes = pl;
		pkt.crc_present = crc;
		send_packet(pkt);
	endtask

	function automatic rpa_in_t random_packet();
		rpa_in_t pkt;
		pkt.implicit_header = 1'($urandom_range(1, 0));
		pkt.crc_present = 1'($urandom_range(1, 0));
		pkt.payload_bytes = 8'($urandom_range(255, 0));
		if ($urandom_range(99, 0) < 12) begin
			pkt.bandwidth_code = 2'($urandom_range(3, 0));
			pkt.spreading_factor = 4'($urandom_range(15, 0));
			pkt.coding_rate = 3'($urandom_range(7, 0));
		end else begin
			pkt.bandwidth_code = 2'($urandom_range(int'(BW_500K), int'(BW_125K)));
			pkt.spreading_factor = 4'($urandom_range(int'(SF_MAX), int'(SF_MIN)));
			pkt.coding_rate = 3'($urandom_range(int'(CR_MAX), int'(CR_MIN)));
		end
		if ($urandom_range(1, 0) == 1)
			pkt.preamble_symbols = 16'($urandom_range(16, 0));
		else
			pkt.preamble_symbols = 16'($urandom_range(65535, 0));
		return pkt;
	endfunction

	task automatic test_directed_extremes();
		send_fields(BW_125K, SF_MIN, CR_MIN, 16'd0, 1'b0, 8'd0, 1'b0);
		send_fields(BW_500K, SF_MIN, CR_MAX, 16'd65535, 1'b1, 8'd255, 1'b1);
		// Largest airtime: slowest bandwidth, longest spreading, longest field settings.
		send_fields(BW_125K, SF_MAX, CR_MAX, 16'd65535, 1'b0, 8'd255, 1'b1);
		send_fields(BW_250K, 4'd9, 3'd2, 16'd8, 1'b0, 8'd20, 1'b1);
		send_fields(BW_500K, 4'd10, 3'd3, 16'd12, 1'b1, 8'd64, 1'b0);
		// Low data rate optimisation on at 125 kHz, off at the wider bandwidths.
		send_fields(BW_125K, SF_LDR, 3'd1, 16'd8, 1'b0, 8'd51, 1'b1);
		send_fields(BW_125K, SF_MAX, 3'd4, 16'd8, 1'b0, 8'd51, 1'b1);
		send_fields(BW_250K, SF_MAX, 3'd4, 16'd8, 1'b0, 8'd51, 1'b1);
		send_fields(BW_500K, SF_LDR, 3'd2, 16'd8, 1'b0, 8'd51, 1'b1);
		// Payload term exactly zero, then negative.
		send_fields(BW_125K, 4'd7, 3'd1, 16'd8, 1'b0, 8'd0, 1'b0);
		send_fields(BW_125K, SF_MAX, 3'd4, 16'd8, 1'b1, 8'd0, 1'b0);
		send_fields(BW_250K, SF_MAX, 3'd3, 16'd0, 1'b1, 8'd1, 1'b0);
	endtask

	task automatic test_saturation();
		send_fields(BW_UNUSED, 4'd8, 3'd2, 16'd8, 1'b0, 8'd10, 1'b1);
		send_fields(BW_125K, 4'd0, 3'd1, 16'd8, 1'b0, 8'd10, 1'b1);
		send_fields(BW_250K, 4'd5, 3'd2, 16'd8, 1'b1, 8'd200, 1'b0);
		send_fields(BW_125K, 4'd13, 3'd3, 16'd8, 1'b0, 8'd100, 1'b1);
		send_fields(BW_UNUSED, 4'd15, 3'd4, 16'd65535, 1'b1, 8'd255, 1'b1);
		send_fields(BW_500K, 4'd9, 3'd0, 16'd8, 1'b0, 8'd30, 1'b0);
		send_fields(BW_250K, 4'd9, 3'd5, 16'd8, 1'b0, 8'd30, 1'b0);
		send_fields(BW_125K, 4'd11, 3'd7, 16'd8, 1'b0, 8'd30, 1'b1);
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_packet(random_packet());
	endtask

	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		recv_hold_cycles = 150;
		repeat (40)
			send_packet(random_packet());
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed_extremes();
		test_saturation();
		test_random_traffic(200, 33, 57);
		test_random_traffic(200, 57, 33);
		test_output_stall();
		test_random_traffic(200, 0, 0);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_timing.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d packet descriptions and checked %0d results, directed extremes,",
			packets_sent, results_checked);
		$display("saturated codes, random traffic with idling on both sides and a long output stall.");
		if (mismatch_count == 0 && expected_timing.size() == 0) begin
			$display("PASS radio_packet_airtime");
		end else begin
			$display("FAIL radio_packet_airtime");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("FAIL radio_packet_airtime");
		$finish;
	end

endmodule
